// ===== design/lzssd_pkg.sv =====
// Shared constants for the LZSS stream decompressor.
`default_nettype none

package lzssd_pkg;

	localparam int OFFSET_BITS_DEF = 11;
	localparam int LENGTH_BITS_DEF = 5;

	// Shortest run that a reference word encodes.
	localparam int MIN_RUN = 3;
	localparam int FLAGS_PER_BYTE = 8;

	localparam logic [2:0] FLAG_BYTES_RESET = 3'd2;
	localparam logic [2:0] FLAG_BYTES_MAX = 3'd4;

endpackage

`default_nettype wire

// ===== design/lzss_stream_decompressor.sv =====
// Top level of the LZSS stream decompressor.
`default_nettype none

// LZSS stream decompressor. Compressed bytes enter one per transaction on the
// in_* channel; decompressed bytes leave one per transaction on the out_*
// channel, with last_of_run marking the final byte caused by an input byte.
// A flag word of n configured bytes (0 acts as 1, 5..7 as 4) leads each
// group of 8*n items; a clear flag is a literal, a set flag a little-endian
// reference word of ceil((OFFSET_BITS+LENGTH_BITS)/8) bytes holding a distance
// and a run length minus 3. Flag and reference bytes are never stalled; a
// literal is accepted even while the previous result waits in the output
// register, as long as that register drains in the same cycle. A run of L
// bytes (3 to 2^LENGTH_BITS+2) reads each byte from the window in ST_COPY_RD
// and writes it back and presents it in ST_COPY_WR, which waits while the
// output is full and stalled; the input is stalled for the run. The window
// reads as all zeros after reset without a clearing pass: it tracks its fill
// and masks entries never written. The user must write configuration through
// cfg_wr_en / cfg_wr_data while the block is idle; the block does not enforce it.
module lzss_stream_decompressor #(
	parameter int OFFSET_BITS = lzssd_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = lzssd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [2:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] out_byte,
	output logic            last_of_run
);

	import lzssd_pkg::*;

	localparam int REF_BYTES = (OFFSET_BITS + LENGTH_BITS + 7) / 8;
	localparam int REF_W = REF_BYTES * 8;
	localparam int CNT_W = LENGTH_BITS + 1;

	typedef enum logic [4:0] {
		ST_FLAG    = 5'b00001,
		ST_ITEM    = 5'b00010,
		ST_REF     = 5'b00100,
		ST_COPY_RD = 5'b01000,
		ST_COPY_WR = 5'b10000
	} state_t;

	state_t                 st_q;
	logic [2:0]             flag_bytes_q;
	logic [31:0]            flag_q;
	logic [5:0]             flags_left_q;
	logic [1:0]             seen_q;
	logic [REF_W-1:0]       ref_q;
	logic [OFFSET_BITS-1:0] wp_q;
	logic [OFFSET_BITS-1:0] src_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [7:0]             out_byte_q;
	logic                   last_q;

	logic                   out_free;
	logic                   in_acc;
	logic [2:0]             n_eff;
	logic [2:0]             seen_inc;
	logic [REF_W-1:0]       ref_full;
	logic                   ref_done;
	logic [OFFSET_BITS-1:0] ref_dist;
	logic [LENGTH_BITS-1:0] len_field;
	logic [5:0]             flags_dec;
	logic                   lit_go;
	logic                   copy_go;

	logic                   win_we;
	logic [7:0]             win_wdata;
	logic                   win_re;
	logic [7:0]             win_rdata;

	// The output register is free if empty or draining this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// Stall during runs, and hold a literal until the output register has room.
	always_comb begin
		case (st_q)
			ST_FLAG: in_stall = 1'b0;
			ST_REF:  in_stall = 1'b0;
			ST_ITEM: in_stall = !flag_q[0] && !out_free;
			default: in_stall = 1'b1;
		endcase
	end

	assign in_acc = in_valid && !in_stall;

	always_comb begin
		if (flag_bytes_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (flag_bytes_q > FLAG_BYTES_MAX) begin
			n_eff = FLAG_BYTES_MAX;
		end else begin
			n_eff = flag_bytes_q;
		end
	end

	assign seen_inc = {1'b0, seen_q} + 3'd1;
	assign flags_dec = flags_left_q - 6'd1;

	// Reference word as it stands once the current byte is merged in.
	always_comb begin
		if (st_q == ST_ITEM) begin
			ref_full = REF_W'(in_byte);
			ref_done = (3'd1 >= 3'(REF_BYTES));
		end else begin
			ref_full = ref_q | (REF_W'(in_byte) << {seen_q, 3'b000});
			ref_done = (seen_inc >= 3'(REF_BYTES));
		end
	end

	assign ref_dist = ref_full[OFFSET_BITS-1:0];
	assign len_field = ref_full[OFFSET_BITS +: LENGTH_BITS];

	assign lit_go = in_acc && (st_q == ST_ITEM) && !flag_q[0];
	assign copy_go = (st_q == ST_COPY_WR) && out_free;

	assign win_we = lit_go || copy_go;
	assign win_wdata = lit_go ? in_byte : win_rdata;
	assign win_re = (st_q == ST_COPY_RD);

	lzssd_window #(
		.ADDR_W (OFFSET_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (win_we),
		.wr_addr (wp_q),
		.wr_data (win_wdata),
		.rd_en   (win_re),
		.rd_addr (src_q),
		.rd_data (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bytes_q <= FLAG_BYTES_RESET;
		end else if (cfg_wr_en) begin
			flag_bytes_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_FLAG;
			flag_q       <= '0;
			flags_left_q <= '0;
			seen_q       <= '0;
			ref_q        <= '0;
			wp_q         <= '0;
			src_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_FLAG: begin
					if (in_acc) begin
						flag_q <= flag_q | (32'(in_byte) << {seen_q, 3'b000});
						if (seen_inc >= n_eff) begin
							flags_left_q <= 6'(32'(n_eff) * FLAGS_PER_BYTE);
							seen_q       <= '0;
							st_q         <= ST_ITEM;
						end else begin
							seen_q <= seen_inc[1:0];
						end
					end
				end
				ST_ITEM: begin
					if (in_acc) begin
						flags_left_q <= flags_dec;
						if (!flag_q[0]) begin
							wp_q <= wp_q + OFFSET_BITS'(1);
							if (flags_dec == 6'd0) begin
								flag_q <= '0;
								st_q   <= ST_FLAG;
							end else begin
								flag_q <= flag_q >> 1;
							end
						end else begin
							flag_q <= flag_q >> 1;
							ref_q  <= ref_full;
							if (ref_done) begin
								src_q  <= wp_q - ref_dist - OFFSET_BITS'(1);
								cnt_q  <= CNT_W'(len_field) + CNT_W'(MIN_RUN - 1);
								seen_q <= '0;
								st_q   <= ST_COPY_RD;
							end else begin
								seen_q <= 2'd1;
								st_q   <= ST_REF;
							end
						end
					end
				end
				ST_REF: begin
					if (in_acc) begin
						ref_q <= ref_full;
						if (ref_done) begin
							src_q  <= wp_q - ref_dist - OFFSET_BITS'(1);
							cnt_q  <= CNT_W'(len_field) + CNT_W'(MIN_RUN - 1);
							seen_q <= '0;
							st_q   <= ST_COPY_RD;
						end else begin
							seen_q <= seen_inc[1:0];
						end
					end
				end
				ST_COPY_RD: begin
					st_q <= ST_COPY_WR;
				end
				ST_COPY_WR: begin
					if (copy_go) begin
						wp_q  <= wp_q + OFFSET_BITS'(1);
						src_q <= src_q + OFFSET_BITS'(1);
						if (cnt_q == '0) begin
							if (flags_left_q == 6'd0) begin
								flag_q <= '0;
								st_q   <= ST_FLAG;
							end else begin
								st_q <= ST_ITEM;
							end
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
							st_q  <= ST_COPY_RD;
						end
					end
				end
				default: begin
					st_q <= ST_FLAG;
				end
			endcase

			// Load a new result, or drop the held one once taken.
			if (lit_go || copy_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload: loaded with each result, held while stalled.
	always_ff @(posedge clk) begin
		if (lit_go) begin
			out_byte_q <= in_byte;
			last_q     <= 1'b1;
		end else if (copy_go) begin
			out_byte_q <= win_rdata;
			last_q     <= (cnt_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last_of_run = last_q;

`ifndef ASSERT_OFF
	a_copy_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY_RD || st_q == ST_COPY_WR) |-> in_stall)
		else $error("input accepted during a run");

	a_read_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY_RD) |=> (st_q == ST_COPY_WR))
		else $error("window read not followed by write-back");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(copy_go && cnt_q == '0) |=> (st_q == ST_ITEM || st_q == ST_FLAG))
		else $error("run did not end after its last byte");

	a_flags_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flags_left_q <= 6'd32)
		else $error("flag count out of range");
`endif

endmodule

`default_nettype wire

// ===== design/lzssd_window.sv =====
// History window: one write port, one registered read port, fill-count masking.
`default_nettype none

module lzssd_window #(
	parameter int ADDR_W = lzssd_pkg::OFFSET_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [7:0]        rd_data
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [7:0]      mem [DEPTH];
	logic [7:0]      rd_q;
	logic            rd_valid_q;
	// Writes arrive at consecutive addresses from zero, so the entries written
	// so far are exactly those below the fill count.
	logic [ADDR_W:0] fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en && (fill_q != (ADDR_W+1)'(DEPTH))) begin
				fill_q <= fill_q + (ADDR_W+1)'(1);
			end
			if (rd_en) begin
				rd_valid_q <= ({1'b0, rd_addr} < fill_q);
			end
		end
	end

	// Entries never written read as zero.
	assign rd_data = rd_valid_q ? rd_q : 8'h00;

endmodule

`default_nettype wire
